// ===== rtl/kst_pkg.sv =====
// Shared types and constants of the keyboard serial transmitter.
// No dependencies; used by kst_seq and keyboard_serial_transmitter_top.
package kst_pkg;

  localparam int CODE_BITS  = 8;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int BITS_W     = 4;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SEND = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_GAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SETUP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_STEP  = 3'd6;

  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST = 18'd143000;
  localparam logic [7:0] LEAD_PULSE_RST = 8'd15;
  localparam logic [7:0] LEAD_GAP_RST   = 8'd100;
  localparam logic [7:0] DATA_SETUP_RST = 8'd18;
  localparam logic [7:0] CLOCK_LOW_RST  = 8'd15;
  localparam logic [7:0] CLOCK_HIGH_RST = 8'd13;
  localparam logic [7:0] SYNC_STEP_RST  = 8'd20;

  localparam logic [BITS_W-1:0] CODE_BITS_CNT = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_S_WAITHIGH = 4'd1,
    PH_S_LEAD     = 4'd2,
    PH_S_GAP      = 4'd3,
    PH_S_SETUP    = 4'd4,
    PH_S_CLKLOW   = 4'd5,
    PH_S_TAIL     = 4'd6,
    PH_Y_ASSERT   = 4'd7,
    PH_Y_CLKLOW   = 4'd8,
    PH_Y_CLKHIGH  = 4'd9,
    PH_H_WAITHIGH = 4'd10,
    PH_H_WAITLOW  = 4'd11
  } phase_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CODE_BITS-1:0] key_code;
    logic                 data_line_level;
  } in_beat_t;

  typedef struct packed {
    logic clock_level;
    logic data_drive;
    logic busy_res;
    logic finished;
    logic handshake_ok;
  } out_beat_t;

endpackage

// ===== rtl/kst_seq.sv =====
// Transmit sequencer: timing registers, phase machine, shift register.
// Depends on kst_pkg; instantiated by keyboard_serial_transmitter_top.
module kst_seq #(
  parameter int TIMER_BITS = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kst_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          beat_en,
  input  kst_pkg::in_beat_t             beat,
  output kst_pkg::out_beat_t            res
);

  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

  logic [kst_pkg::CFG_DATA_W-1:0] timeout_r;
  logic [7:0] lead_pulse_r, lead_gap_r, data_setup_r, clock_low_r, clock_high_r, sync_step_r;

  kst_pkg::phase_t phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] cnt_r, cnt_nxt, cnt_dec;
  logic [kst_pkg::CODE_BITS-1:0] shift_r, shift_nxt;
  logic [kst_pkg::BITS_W-1:0] bits_r, bits_nxt, bits_dec;
  logic clock_out_r, clock_out_nxt, data_out_r, data_out_nxt;
  logic busy, busy_nxt, is_tick, last, fin, ok;

  function automatic logic [TIMER_BITS-1:0] load_val(input logic [kst_pkg::CFG_DATA_W-1:0] n);
    logic [32:0] w;
    begin
      w = 33'(n);
      if (w == 33'd0) w = 33'd1;
      if (w > TIMER_MAX) w = TIMER_MAX;
      return w[TIMER_BITS-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= kst_pkg::TIMEOUT_RST;
      lead_pulse_r <= kst_pkg::LEAD_PULSE_RST;
      lead_gap_r   <= kst_pkg::LEAD_GAP_RST;
      data_setup_r <= kst_pkg::DATA_SETUP_RST;
      clock_low_r  <= kst_pkg::CLOCK_LOW_RST;
      clock_high_r <= kst_pkg::CLOCK_HIGH_RST;
      sync_step_r  <= kst_pkg::SYNC_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kst_pkg::REG_TIMEOUT:    timeout_r    <= cfg_data;
        kst_pkg::REG_LEAD_PULSE: lead_pulse_r <= cfg_data[7:0];
        kst_pkg::REG_LEAD_GAP:   lead_gap_r   <= cfg_data[7:0];
        kst_pkg::REG_DATA_SETUP: data_setup_r <= cfg_data[7:0];
        kst_pkg::REG_CLOCK_LOW:  clock_low_r  <= cfg_data[7:0];
        kst_pkg::REG_CLOCK_HIGH: clock_high_r <= cfg_data[7:0];
        kst_pkg::REG_SYNC_STEP:  sync_step_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign busy     = (phase_r != kst_pkg::PH_IDLE) && (phase_r <= kst_pkg::PH_H_WAITLOW);
  assign is_tick  = (beat.kind == kst_pkg::KIND_TICK);
  assign cnt_dec  = (cnt_r != '0) ? cnt_r - TIMER_BITS'(1) : '0;
  assign last     = (cnt_dec == '0);
  assign bits_dec = (bits_r != '0) ? bits_r - kst_pkg::BITS_W'(1) : '0;

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    bits_nxt      = bits_r;
    clock_out_nxt = clock_out_r;
    data_out_nxt  = data_out_r;
    case (beat.kind)
      kst_pkg::KIND_TICK: begin
        if (!busy) begin
          phase_nxt = kst_pkg::PH_IDLE;
        end else begin
          case (phase_r)
            kst_pkg::PH_S_WAITHIGH: begin
              if (beat.data_line_level) begin
                data_out_nxt = 1'b0;
                cnt_nxt      = load_val(18'(lead_pulse_r));
                phase_nxt    = kst_pkg::PH_S_LEAD;
              end
            end
            kst_pkg::PH_S_LEAD: begin
              cnt_nxt = cnt_dec;
              if (last) begin
                data_out_nxt = 1'b1;
                bits_nxt     = kst_pkg::CODE_BITS_CNT;
                cnt_nxt      = load_val(18'(lead_gap_r));
                phase_nxt    = kst_pkg::PH_S_GAP;
              end
            end
            kst_pkg::PH_S_GAP: begin
              cnt_nxt = cnt_dec;
              if (last) begin
                data_out_nxt = shift_r[kst_pkg::CODE_BITS-1];
                shift_nxt    = {shift_r[kst_pkg::CODE_BITS-2:0], 1'b0};
                cnt_nxt      = load_val(18'(data_setup_r));
                phase_nxt    = kst_pkg::PH_S_SETUP;
              end
            end
            kst_pkg::PH_S_SETUP: begin
              cnt_nxt = cnt_dec;
              if (last) begin
                clock_out_nxt = 1'b0;
                cnt_nxt       = load_val(18'(clock_low_r));
                phase_nxt     = kst_pkg::PH_S_CLKLOW;
              end
            end
            kst_pkg::PH_S_CLKLOW: begin
              cnt_nxt = cnt_dec;
              if (last) begin
                clock_out_nxt = 1'b1;
                cnt_nxt       = load_val(18'(clock_high_r));
                bits_nxt      = bits_dec;
                phase_nxt     = (bits_dec != '0) ? kst_pkg::PH_S_GAP : kst_pkg::PH_S_TAIL;
              end
            end
            kst_pkg::PH_S_TAIL, kst_pkg::PH_Y_CLKHIGH: begin
              cnt_nxt = cnt_dec;
              if (last) begin
                data_out_nxt = 1'b1;
                cnt_nxt      = load_val(timeout_r);
                phase_nxt    = kst_pkg::PH_H_WAITHIGH;
              end
            end
            kst_pkg::PH_Y_ASSERT: begin
              cnt_nxt = cnt_dec;
              if (last) begin
                clock_out_nxt = 1'b0;
                cnt_nxt       = load_val(18'(sync_step_r));
                phase_nxt     = kst_pkg::PH_Y_CLKLOW;
              end
            end
            kst_pkg::PH_Y_CLKLOW: begin
              cnt_nxt = cnt_dec;
              if (last) begin
                clock_out_nxt = 1'b1;
                cnt_nxt       = load_val(18'(sync_step_r));
                phase_nxt     = kst_pkg::PH_Y_CLKHIGH;
              end
            end
            kst_pkg::PH_H_WAITHIGH: begin
              cnt_nxt = cnt_dec;
              if (beat.data_line_level) begin
                phase_nxt = last ? kst_pkg::PH_IDLE : kst_pkg::PH_H_WAITLOW;
              end
            end
            kst_pkg::PH_H_WAITLOW: begin
              if (!beat.data_line_level) begin
                phase_nxt = kst_pkg::PH_IDLE;
              end else begin
                cnt_nxt = cnt_dec;
                if (last) phase_nxt = kst_pkg::PH_IDLE;
              end
            end
            default: phase_nxt = kst_pkg::PH_IDLE;
          endcase
        end
      end
      kst_pkg::KIND_SEND: begin
        if (!busy) begin
          shift_nxt = ~{beat.key_code[kst_pkg::CODE_BITS-2:0],
                        beat.key_code[kst_pkg::CODE_BITS-1]};
          bits_nxt  = '0;
          cnt_nxt   = '0;
          phase_nxt = kst_pkg::PH_S_WAITHIGH;
        end
      end
      kst_pkg::KIND_SYNC: begin
        if (!busy) begin
          data_out_nxt = 1'b0;
          cnt_nxt      = load_val(18'(sync_step_r));
          phase_nxt    = kst_pkg::PH_Y_ASSERT;
        end
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    fin = 1'b0;
    ok  = 1'b0;
    if (is_tick && busy) begin
      case (phase_r)
        kst_pkg::PH_H_WAITHIGH: fin = beat.data_line_level && last;
        kst_pkg::PH_H_WAITLOW: begin
          fin = !beat.data_line_level || last;
          ok  = !beat.data_line_level;
        end
        default: ;
      endcase
    end
    busy_nxt         = (phase_nxt != kst_pkg::PH_IDLE) && (phase_nxt <= kst_pkg::PH_H_WAITLOW);
    res.clock_level  = clock_out_nxt;
    res.data_drive   = data_out_nxt;
    res.busy_res     = busy_nxt;
    res.finished     = fin;
    res.handshake_ok = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= kst_pkg::PH_IDLE;
      cnt_r       <= '0;
      shift_r     <= '0;
      bits_r      <= '0;
      clock_out_r <= 1'b1;
      data_out_r  <= 1'b1;
    end else if (beat_en) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      clock_out_r <= clock_out_nxt;
      data_out_r  <= data_out_nxt;
    end
  end

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == kst_pkg::PH_IDLE) |-> (clock_out_r && data_out_r))
    else $error("lines not released while idle");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= kst_pkg::CODE_BITS_CNT)
    else $error("bit counter out of range");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_en && res.finished) |=> (phase_r == kst_pkg::PH_IDLE))
    else $error("sequence finished but not idle");

  a_ok_needs_finish: assert property (@(posedge clk) disable iff (!rst_n)
    res.handshake_ok |-> (res.finished && !res.busy_res))
    else $error("handshake ok without finish");

endmodule

// ===== rtl/keyboard_serial_transmitter_top.sv =====
// Top level of the keyboard serial transmitter: ports, result buffer.
// Depends on kst_pkg and kst_seq.
//
//   port group  direction  flow control    payload
//   in_         in         valid / stall   kst_pkg::in_beat_t
//   out_        out        valid / stall   kst_pkg::out_beat_t
//   cfg_        in         valid / ready   register index, 18-bit data
//
// One beat per cycle is accepted while in_stall is low; each beat yields one result
// beat, registered behind the single sequencer stage in the output register or skid.
// A two-entry result buffer (output register plus skid) stalls the input
// only when both entries hold results that the consumer has not taken.
// Synchronous active-low reset idles the sequencer, releases both lines and
// loads the timing registers with their defaults; cfg_ready is always high.
module keyboard_serial_transmitter_top #(
  parameter int TIMER_BITS = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kst_pkg::in_beat_t              in_beat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kst_pkg::out_beat_t             out_beat,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kst_pkg::CFG_DATA_W-1:0] cfg_data
);

  kst_pkg::out_beat_t res, out_beat_r, out_beat_nxt, skid_beat_r, skid_beat_nxt;
  logic out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic accept, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  kst_seq #(
    .TIMER_BITS(TIMER_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .beat_en  (accept),
    .beat     (in_beat),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_beat_nxt   = out_beat_r;
    skid_valid_nxt = skid_valid_r;
    skid_beat_nxt  = skid_beat_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_beat_nxt   = skid_beat_r;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_valid_nxt = 1'b1;
        out_beat_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_beat_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_beat_r  <= out_beat_nxt;
    skid_beat_r <= skid_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("accepted beat lost while output stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid beat not moved to output");

endmodule

// ===== dv/keyboard_serial_transmitter_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keyboard_serial_transmitter_top: tick, send and sync beats
// with randomized line levels, checked beat by beat against an in-bench line predictor.
// Depends on kst_pkg and the RTL of keyboard_serial_transmitter_top.
module keyboard_serial_transmitter_top_test;
  import kst_pkg::*;

  localparam int          TIMING_REGS  = 7;
  localparam int          SYNC_PHASES  = 3;
  localparam int          PAD_W        = CFG_DATA_W - CODE_BITS;
  localparam int          HOLD_CYCLES  = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [1:0] {HS_RUNNING, HS_ACK, HS_TIMEOUT} hs_verdict_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_beat_t  pending_beats[$];
  out_beat_t expected_lines[$];
  int unsigned beats_queued = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 14;
  int unsigned rx_idle_pct = 59;
  bit          hold_armed = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;

  logic [CFG_DATA_W-1:0] timing_reg [TIMING_REGS];
  phase_t                seq_phase;
  logic [CFG_DATA_W-1:0] interval_left;
  logic [CODE_BITS-1:0]  code_shift;
  logic [BITS_W-1:0]     bits_remaining;
  logic                  clk_drive;
  logic                  data_drv;

  keyboard_serial_transmitter_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CFG_DATA_W-1:0] ticks_for(logic [CFG_DATA_W-1:0] v);
    return (v == '0) ? CFG_DATA_W'(1) : v;
  endfunction

  function automatic bit interval_done();
    if (interval_left != '0) interval_left--;
    return interval_left == '0;
  endfunction

  function automatic hs_verdict_t tick_sequencer(logic lvl);
    hs_verdict_t verdict;
    verdict = HS_RUNNING;
    case (seq_phase)
      PH_S_WAITHIGH: if (lvl) begin
        data_drv = 1'b0;
        interval_left = ticks_for(timing_reg[REG_LEAD_PULSE]);
        seq_phase = PH_S_LEAD;
      end
      PH_S_LEAD: if (interval_done()) begin
        data_drv = 1'b1;
        bits_remaining = CODE_BITS_CNT;
        interval_left = ticks_for(timing_reg[REG_LEAD_GAP]);
        seq_phase = PH_S_GAP;
      end
      PH_S_GAP: if (interval_done()) begin
        data_drv = code_shift[CODE_BITS-1];
        code_shift = code_shift << 1;
        interval_left = ticks_for(timing_reg[REG_DATA_SETUP]);
        seq_phase = PH_S_SETUP;
      end
      PH_S_SETUP: if (interval_done()) begin
        clk_drive = 1'b0;
        interval_left = ticks_for(timing_reg[REG_CLOCK_LOW]);
        seq_phase = PH_S_CLKLOW;
      end
      PH_S_CLKLOW: if (interval_done()) begin
        clk_drive = 1'b1;
        interval_left = ticks_for(timing_reg[REG_CLOCK_HIGH]);
        if (bits_remaining != '0) bits_remaining--;
        seq_phase = (bits_remaining != '0) ? PH_S_GAP : PH_S_TAIL;
      end
      PH_S_TAIL, PH_Y_CLKHIGH: if (interval_done()) begin
        data_drv = 1'b1;
        interval_left = ticks_for(timing_reg[REG_TIMEOUT]);
        seq_phase = PH_H_WAITHIGH;
      end
      PH_Y_ASSERT: if (interval_done()) begin
        clk_drive = 1'b0;
        interval_left = ticks_for(timing_reg[REG_SYNC_STEP]);
        seq_phase = PH_Y_CLKLOW;
      end
      PH_Y_CLKLOW: if (interval_done()) begin
        clk_drive = 1'b1;
        interval_left = ticks_for(timing_reg[REG_SYNC_STEP]);
        seq_phase = PH_Y_CLKHIGH;
      end
      PH_H_WAITHIGH: begin
        if (interval_left != '0) interval_left--;
        if (lvl) begin
          if (interval_left == '0) begin
            verdict = HS_TIMEOUT;
            seq_phase = PH_IDLE;
          end else begin
            seq_phase = PH_H_WAITLOW;
          end
        end
      end
      PH_H_WAITLOW: begin
        if (!lvl) begin
          verdict = HS_ACK;
          seq_phase = PH_IDLE;
        end else if (interval_done()) begin
          verdict = HS_TIMEOUT;
          seq_phase = PH_IDLE;
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    return verdict;
  endfunction

  function automatic out_beat_t predict_lines(in_beat_t b);
    hs_verdict_t verdict;
    out_beat_t   r;
    verdict = HS_RUNNING;
    if (b.kind == KIND_TICK) begin
      if (seq_phase != PH_IDLE) verdict = tick_sequencer(b.data_line_level);
    end else if (b.kind == KIND_SEND && seq_phase == PH_IDLE) begin
      code_shift = ~{b.key_code[CODE_BITS-2:0], b.key_code[CODE_BITS-1]};
      bits_remaining = '0;
      interval_left = '0;
      seq_phase = PH_S_WAITHIGH;
    end else if (b.kind == KIND_SYNC && seq_phase == PH_IDLE) begin
      data_drv = 1'b0;
      interval_left = ticks_for(timing_reg[REG_SYNC_STEP]);
      seq_phase = PH_Y_ASSERT;
    end
    r.clock_level  = clk_drive;
    r.data_drive   = data_drv;
    r.busy_res     = (seq_phase != PH_IDLE);
    r.finished     = (verdict != HS_RUNNING);
    r.handshake_ok = (verdict == HS_ACK);
    return r;
  endfunction

  // Driver: hold a stalled beat, advance the backlog otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      seq_phase = PH_IDLE;
      interval_left = '0;
      code_shift = '0;
      bits_remaining = '0;
      clk_drive = 1'b1;
      data_drv = 1'b1;
    end else begin
      if (in_valid && !in_stall) expected_lines.push_back(predict_lines(in_beat));
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_beat <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endtask

  // Monitor and result-side stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatches++;
        end else begin
          check_field("clock_level", expected_lines[0].clock_level, out_beat.clock_level);
          check_field("data_drive", expected_lines[0].data_drive, out_beat.data_drive);
          check_field("busy_res", expected_lines[0].busy_res, out_beat.busy_res);
          check_field("finished", expected_lines[0].finished, out_beat.finished);
          check_field("handshake_ok", expected_lines[0].handshake_ok,
                      out_beat.handshake_ok);
          void'(expected_lines.pop_front());
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_armed && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_beat(logic [1:0] kind, logic [CODE_BITS-1:0] code, logic lvl);
    in_beat_t b;
    b.kind = kind;
    b.key_code = code;
    b.data_line_level = lvl;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic add_ticks(int unsigned n, logic lvl, bit any_level);
    repeat (n) add_beat(KIND_TICK, CODE_BITS'($urandom), any_level ? 1'($urandom) : lvl);
  endtask

  function automatic int unsigned send_ticks();
    return ticks_for(timing_reg[REG_LEAD_PULSE]) + ticks_for(timing_reg[REG_LEAD_GAP]) +
           CODE_BITS * (ticks_for(timing_reg[REG_DATA_SETUP]) +
                        ticks_for(timing_reg[REG_CLOCK_LOW]) +
                        ticks_for(timing_reg[REG_CLOCK_HIGH]));
  endfunction

  // Host side: optional late release, then a high run, then ack or let it time out.
  task automatic add_handshake();
    int unsigned limit;
    int unsigned lows;
    limit = ticks_for(timing_reg[REG_TIMEOUT]);
    lows = ($urandom_range(3) == 0) ? $urandom_range(limit < 6 ? limit + 2 : 5) : 0;
    add_ticks(lows, 1'b0, 1'b0);
    add_ticks($urandom_range(limit < 20 ? limit + 2 : 12, 1), 1'b1, 1'b0);
    if (limit > 40 || $urandom_range(1) == 0) add_beat(KIND_TICK, CODE_BITS'($urandom), 1'b0);
    else add_ticks(limit, 1'b1, 1'b0);
    add_ticks($urandom_range(2), 1'b0, 1'b1);
  endtask

  task automatic add_sequence(logic [1:0] op, logic [CODE_BITS-1:0] code);
    int unsigned body;
    add_beat(op, code, 1'($urandom));
    if (op == KIND_SEND) begin
      if ($urandom_range(2) == 0) add_ticks($urandom_range(4, 1), 1'b0, 1'b0);
      add_beat(KIND_TICK, CODE_BITS'($urandom), 1'b1);
      body = send_ticks();
    end else begin
      body = SYNC_PHASES * ticks_for(timing_reg[REG_SYNC_STEP]);
    end
    if ($urandom_range(5) == 0) body = body + 2 - $urandom_range(4);
    add_ticks(body / 2, 1'b0, 1'b1);
    if ($urandom_range(3) == 0) add_beat(2'($urandom_range(3, 1)), CODE_BITS'($urandom), 1'($urandom));
    add_ticks(body - body / 2, 1'b0, 1'b1);
    add_handshake();
  endtask

  task automatic add_random_traffic(int unsigned n);
    int unsigned stop;
    stop = beats_queued + n;
    while (beats_queued < stop) begin
      case ($urandom_range(9))
        0:       add_beat(2'($urandom_range(3)), CODE_BITS'($urandom), 1'($urandom));
        1, 2, 3: add_sequence(KIND_SYNC, CODE_BITS'($urandom));
        default: add_sequence(KIND_SEND, CODE_BITS'($urandom));
      endcase
    end
  endtask

  task automatic write_timing(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_TIMEOUT) timing_reg[idx] = val;
    else if (idx < TIMING_REGS) timing_reg[idx] = CFG_DATA_W'(val[CODE_BITS-1:0]);
  endtask

  task automatic write_all_timing(int unsigned lo, int unsigned hi, logic [CFG_DATA_W-1:0] timeout);
    write_timing(REG_TIMEOUT, timeout);
    for (int i = 1; i < TIMING_REGS; i++)
      write_timing(CFG_IDX_W'(i), {PAD_W'($urandom), CODE_BITS'($urandom_range(hi, lo))});
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_lines.size() != 0);
  endtask

  initial begin
    timing_reg[REG_TIMEOUT]    = TIMEOUT_RST;
    timing_reg[REG_LEAD_PULSE] = CFG_DATA_W'(LEAD_PULSE_RST);
    timing_reg[REG_LEAD_GAP]   = CFG_DATA_W'(LEAD_GAP_RST);
    timing_reg[REG_DATA_SETUP] = CFG_DATA_W'(DATA_SETUP_RST);
    timing_reg[REG_CLOCK_LOW]  = CFG_DATA_W'(CLOCK_LOW_RST);
    timing_reg[REG_CLOCK_HIGH] = CFG_DATA_W'(CLOCK_HIGH_RST);
    timing_reg[REG_SYNC_STEP]  = CFG_DATA_W'(SYNC_STEP_RST);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset timing: idle ticks, unused kind, commands while busy, data held low.
    add_beat(KIND_TICK, 8'h00, 1'b0);
    add_beat(KIND_TICK, 8'hFF, 1'b1);
    add_beat(KIND_UNUSED, 8'h5A, 1'b1);
    add_beat(KIND_SEND, 8'h80, 1'b0);
    add_beat(KIND_SYNC, 8'h3C, 1'b1);
    add_beat(KIND_UNUSED, 8'hC3, 1'b0);
    add_beat(KIND_SEND, 8'h7F, 1'b1);
    add_ticks(3, 1'b0, 1'b0);
    add_beat(KIND_TICK, 8'h00, 1'b1);
    add_ticks(send_ticks(), 1'b0, 1'b1);
    add_handshake();
    add_sequence(KIND_SYNC, 8'hFF);
    wait_drained();

    // Short random timing, junk in the upper data bits, unmapped index.
    write_all_timing(0, 4, CFG_DATA_W'($urandom_range(40, 8)));
    write_timing(REG_UNMAPPED, CFG_DATA_W'($urandom));
    @(negedge clk);
    add_sequence(KIND_SEND, 8'h00);
    add_sequence(KIND_SEND, 8'hFF);
    add_random_traffic(100);
    hold_armed = 1'b1;
    wait_drained();

    tx_idle_pct = 59;
    rx_idle_pct = 14;
    write_all_timing(0, 0, CFG_DATA_W'(1));
    add_random_traffic(60);
    wait_drained();
    write_all_timing(1, 1, CFG_DATA_W'($urandom_range(3, 1)));
    add_random_traffic(60);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_all_timing(1, 6, '1);
    add_random_traffic(30);
    wait_drained();

    write_all_timing(1, 6, CFG_DATA_W'($urandom_range(30, 3)));
    add_random_traffic(80);
    wait_drained();

    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== keyboard_serial_transmitter_top.f =====
rtl/kst_pkg.sv
rtl/kst_seq.sv
rtl/keyboard_serial_transmitter_top.sv
dv/keyboard_serial_transmitter_top_test.sv
